// ===== rtl/ssebin_pkg.sv =====
package ssebin_pkg;

  localparam int IDX_W       = 6;
  localparam int GRID_W      = 7;
  localparam int SHIFT_W     = 6;
  localparam int SEL_W       = 7;
  localparam int SHELL_W     = 8;
  localparam int R2_W        = 16;
  localparam int ACC_W       = 64;
  localparam int ENERGY_W    = 63;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int OUT_TDATA_W = 72;

  localparam logic [GRID_W-1:0]  GRID_RESET  = 7'd64;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd37;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_NX    = 2'd0,
    CFG_GRID_NY    = 2'd1,
    CFG_GRID_NZ    = 2'd2,
    CFG_NORM_SHIFT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_ACCUM = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [SEL_W-1:0] addr;
    logic             valid;
    logic             flag;
    logic [ACC_W-1:0] sum;
  } store_wr_t;

  typedef struct packed {
    logic             flag;
    logic [ACC_W-1:0] sum;
  } store_rd_t;

endpackage

// ===== rtl/ssebin_radius.sv =====
module ssebin_radius (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [ssebin_pkg::IDX_W-1:0]  idx_x_i,
  input  logic [ssebin_pkg::IDX_W-1:0]  idx_y_i,
  input  logic [ssebin_pkg::IDX_W-1:0]  idx_z_i,
  input  logic [ssebin_pkg::GRID_W-1:0] grid_nx_i,
  input  logic [ssebin_pkg::GRID_W-1:0] grid_ny_i,
  input  logic [ssebin_pkg::GRID_W-1:0] grid_nz_i,
  output logic                         done_o,
  output logic [ssebin_pkg::SHELL_W-1:0] shell_o
);
  import ssebin_pkg::*;

  function automatic logic [GRID_W-1:0] fold_mag(input logic [IDX_W-1:0] k,
                                                 input logic [GRID_W-1:0] n);
    logic [GRID_W:0]   d;
    logic [GRID_W:0]   m;
    logic [GRID_W-1:0] k7;
    k7 = {1'b0, k};
    d  = {2'b00, k} - {1'b0, n};
    m  = d[GRID_W] ? ((GRID_W+1)'(0) - d) : d;
    return (k7 <= (n >> 1)) ? k7 : m[GRID_W-1:0];
  endfunction

  logic [GRID_W-1:0]    mx, my, mz;
  logic [R2_W-1:0]      r2_calc;
  logic [R2_W-1:0]      r2_r;
  logic [SHELL_W-1:0]   root_r;
  logic [2:0]           cnt_r;
  logic                 run_r;
  logic                 rnd_r;
  logic                 done_r;
  logic [SHELL_W-1:0]   shell_r;
  logic [SHELL_W-1:0]   trial;
  logic [R2_W-1:0]      trial_sq;
  logic [R2_W-1:0]      round_lim;

  assign mx = fold_mag(idx_x_i, grid_nx_i);
  assign my = fold_mag(idx_y_i, grid_ny_i);
  assign mz = fold_mag(idx_z_i, grid_nz_i);
  assign r2_calc = R2_W'({7'd0, mx} * {7'd0, mx}) + R2_W'({7'd0, my} * {7'd0, my})
                 + R2_W'({7'd0, mz} * {7'd0, mz});

  assign trial     = root_r | (SHELL_W'(1) << cnt_r);
  assign trial_sq  = {8'd0, trial} * {8'd0, trial};
  assign round_lim = ({8'd0, root_r} * {8'd0, root_r}) + {8'd0, root_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= rnd_r;
      rnd_r  <= run_r && (cnt_r == 3'd0);
      if (start_i) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == 3'd0)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      r2_r   <= r2_calc;
      root_r <= '0;
      cnt_r  <= 3'd7;
    end else if (run_r) begin
      if (trial_sq <= r2_r) begin
        root_r <= trial;
      end
      cnt_r <= cnt_r - 3'd1;
    end
    if (rnd_r) begin
      shell_r <= root_r + ((r2_r > round_lim) ? SHELL_W'(1) : SHELL_W'(0));
    end
  end

  assign done_o  = done_r;
  assign shell_o = shell_r;

endmodule

// ===== rtl/ssebin_energy.sv =====
module ssebin_energy #(
  parameter int COEF_BITS = 24
) (
  input  logic                              clk,
  input  logic [5:0][COEF_BITS-1:0]         coef_i,
  output logic [ssebin_pkg::ACC_W-1:0]      energy_o
);
  import ssebin_pkg::*;

  localparam int SQ_W  = 2 * COEF_BITS;
  localparam int PR_W  = SQ_W + 1;
  localparam int SUM_W = SQ_W + 3;

  logic [5:0][COEF_BITS-1:0] mag;
  logic [5:0][SQ_W-1:0]      sq_r;
  logic [2:0][PR_W-1:0]      pair_r;
  logic [SUM_W-1:0]          sum_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag[i] = coef_i[i][COEF_BITS-1] ? COEF_BITS'(~coef_i[i] + 1'b1) : coef_i[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      sq_r[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
    end
    for (int j = 0; j < 3; j++) begin
      pair_r[j] <= PR_W'(sq_r[2*j]) + PR_W'(sq_r[2*j+1]);
    end
    sum_r <= SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]) + SUM_W'(pair_r[2]);
  end

  assign energy_o = ACC_W'(sum_r);

endmodule

// ===== rtl/ssebin_store.sv =====
module ssebin_store #(
  parameter int SHELL_COUNT = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en_i,
  input  logic [ssebin_pkg::SEL_W-1:0]  rd_addr_i,
  output ssebin_pkg::store_rd_t         rd_o,
  input  ssebin_pkg::store_wr_t         wr_i
);
  import ssebin_pkg::*;

  localparam int AW = (SHELL_COUNT > 1) ? $clog2(SHELL_COUNT) : 1;

  logic [ACC_W:0]          mem [SHELL_COUNT];
  logic [SHELL_COUNT-1:0]  valid_r;
  logic [ACC_W:0]          rd_q_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= {wr_i.flag, wr_i.sum};
    end
    if (rd_en_i) begin
      rd_q_r   <= mem[rd_addr_i[AW-1:0]];
      rd_vld_r <= valid_r[rd_addr_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_i.en) begin
      valid_r[wr_i.addr[AW-1:0]] <= wr_i.valid;
    end
  end

  assign rd_o.flag = rd_vld_r & rd_q_r[ACC_W];
  assign rd_o.sum  = rd_vld_r ? rd_q_r[ACC_W-1:0] : '0;

endmodule

// ===== rtl/spectral_shell_energy_binning_top.sv =====
// Channel  Direction  Ports                         Contents
// in       slave      in_tvalid/tready/tdata/tuser   tuser: cmd; tdata: indices, coefficients,
//                                                    shell_select
// out      master     out_tvalid/tready/tdata/tuser  tuser: overflowed; tdata: shell_number,
//                                                    shell_energy
// cfg      slave      cfg_valid/ready/index/data     one register write per transaction
//
// An accumulate transaction runs the bit-serial radius square root (8 iterations plus fold
// and rounding), then the read-modify-write of one shell; it returns to idle after the
// rounding when its shell is out of range and is dropped.
// A read transaction runs memory fetch, then readout and clear.
// Reset marks every shell empty at once through per-shell valid bits; no clearing pass.
// A read waits in its last cycle while the output register holds an untaken result.
module spectral_shell_energy_binning_top #(
  parameter int SHELL_COUNT = 128,
  parameter int COEF_BITS   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // index_x, index_y, index_z, u_real, u_imag, v_real, v_imag, w_real, w_imag,
  // shell_select, zero pad
  input  logic [((6*COEF_BITS+32)/8)*8-1:0]     in_tdata,
  // cmd
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // shell_number, shell_energy, zero pad
  output logic [ssebin_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // overflowed
  output logic                                  out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ssebin_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssebin_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssebin_pkg::*;

  localparam int X_LSB   = 0;
  localparam int Y_LSB   = X_LSB + IDX_W;
  localparam int Z_LSB   = Y_LSB + IDX_W;
  localparam int C_LSB   = Z_LSB + IDX_W;
  localparam int SEL_LSB = C_LSB + 6 * COEF_BITS;
  localparam logic [SHELL_W:0] SHELL_LIM = (SHELL_W+1)'(SHELL_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CALC   = 4'b0010,
    ST_FETCH  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [GRID_W-1:0]         grid_nx_r, grid_ny_r, grid_nz_r;
  logic [SHIFT_W-1:0]        norm_shift_r;
  logic                      cmd_r;
  logic [IDX_W-1:0]          idx_x_r, idx_y_r, idx_z_r;
  logic [5:0][COEF_BITS-1:0] coef_r;
  logic [SEL_W-1:0]          tgt_r;
  logic                      hit_r;
  logic                      start_r;
  logic                      in_acc;
  logic                      rad_done;
  logic [SHELL_W-1:0]        rad_shell;
  logic                      shell_hit;
  logic [ACC_W-1:0]          energy;
  store_rd_t                 rd_data;
  store_wr_t                 wr_cmd;
  logic [ACC_W:0]            acc_sum;
  logic [ACC_W-1:0]          shifted;
  logic                      out_free;
  logic                      out_load;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_tdata_r;
  logic                      out_tuser_r;
  logic [ENERGY_W-1:0]       energy_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_nx_r    <= GRID_RESET;
      grid_ny_r    <= GRID_RESET;
      grid_nz_r    <= GRID_RESET;
      norm_shift_r <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_NX:    grid_nx_r    <= cfg_data;
        CFG_GRID_NY:    grid_ny_r    <= cfg_data;
        CFG_GRID_NZ:    grid_nz_r    <= cfg_data;
        CFG_NORM_SHIFT: norm_shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser;
      idx_x_r <= in_tdata[X_LSB +: IDX_W];
      idx_y_r <= in_tdata[Y_LSB +: IDX_W];
      idx_z_r <= in_tdata[Z_LSB +: IDX_W];
      for (int i = 0; i < 6; i++) begin
        coef_r[i] <= in_tdata[C_LSB + i*COEF_BITS +: COEF_BITS];
      end
      tgt_r <= in_tdata[SEL_LSB +: SEL_W];
      hit_r <= ({2'b00, in_tdata[SEL_LSB +: SEL_W]} < SHELL_LIM);
    end else if ((state_r == ST_CALC) && rad_done) begin
      tgt_r <= rad_shell[SEL_W-1:0];
      hit_r <= shell_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      start_r <= in_acc && (in_tuser == CMD_ACCUM);
    end
  end

  ssebin_radius u_radius (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (start_r),
    .idx_x_i   (idx_x_r),
    .idx_y_i   (idx_y_r),
    .idx_z_i   (idx_z_r),
    .grid_nx_i (grid_nx_r),
    .grid_ny_i (grid_ny_r),
    .grid_nz_i (grid_nz_r),
    .done_o    (rad_done),
    .shell_o   (rad_shell)
  );

  assign shell_hit = ({1'b0, rad_shell} < SHELL_LIM);

  ssebin_energy #(
    .COEF_BITS (COEF_BITS)
  ) u_energy (
    .clk      (clk),
    .coef_i   (coef_r),
    .energy_o (energy)
  );

  ssebin_store #(
    .SHELL_COUNT (SHELL_COUNT)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en_i   (state_r == ST_FETCH),
    .rd_addr_i (tgt_r),
    .rd_o      (rd_data),
    .wr_i      (wr_cmd)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign acc_sum    = {1'b0, rd_data.sum} + {1'b0, energy};
  assign shifted    = rd_data.sum >> norm_shift_r;
  assign energy_out = shifted[ACC_W-1] ? '1 : shifted[ENERGY_W-1:0];
  assign out_load   = (state_r == ST_UPDATE) && (cmd_r == CMD_READ) && out_free;

  always_comb begin
    wr_cmd       = '0;
    wr_cmd.addr  = tgt_r;
    if (state_r == ST_UPDATE) begin
      if (cmd_r == CMD_ACCUM) begin
        wr_cmd.en    = 1'b1;
        wr_cmd.valid = 1'b1;
        wr_cmd.flag  = rd_data.flag | acc_sum[ACC_W];
        wr_cmd.sum   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
      end else begin
        wr_cmd.en = hit_r && out_free;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == CMD_READ) ? ST_FETCH : ST_CALC;
        end
      end
      ST_CALC: begin
        if (rad_done) begin
          state_nxt = shell_hit ? ST_FETCH : ST_IDLE;
        end
      end
      ST_FETCH: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if ((cmd_r == CMD_ACCUM) || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {(OUT_TDATA_W - SEL_W - ENERGY_W)'(0),
                      (hit_r ? energy_out : ENERGY_W'(0)), tgt_r};
      out_tuser_r <= hit_r & rd_data.flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
